### rtl/core/e2ecc_pkg.sv
// Shared types, constants and the CRC-64/XZ byte update for the E2E counter checker.
package e2ecc_pkg;

    localparam int MAX_MESSAGE_BYTES = 256;
    localparam int IDX_W             = $clog2(MAX_MESSAGE_BYTES);
    localparam int OFS_W             = 11;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 32;

    localparam logic [63:0] CRC_POLY_REFL = 64'hC96C5795D7870F42;
    localparam logic [63:0] CRC_ALL_ONES  = 64'hFFFFFFFFFFFFFFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_CRC_OFS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CNT_OFS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_ID     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INCL_ID     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELTA   = 3'd4;

    typedef enum logic [2:0] {
        ST_INITIAL   = 3'd0,
        ST_OK        = 3'd1,
        ST_OK_LOST   = 3'd2,
        ST_REPEATED  = 3'd3,
        ST_SYNC      = 3'd4,
        ST_WRONG_CRC = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        SM_VALID   = 2'd0,
        SM_INVALID = 2'd1,
        SM_INIT    = 2'd2,
        SM_NODATA  = 2'd3
    } sm_state_t;

    typedef struct packed {
        logic [OFS_W-1:0] crc_ofs;
        logic [OFS_W-1:0] cnt_ofs;
        logic [31:0]      data_id;
        logic             incl_id;
        logic [7:0]       max_delta;
    } cfg_t;

    // finished message leaving the byte stage
    typedef struct packed {
        logic [63:0] crc_calc;
        logic [63:0] crc_rx;
        logic [31:0] counter;
    } msg_t;

    typedef struct packed {
        logic        crc_ok;
        logic [31:0] counter;
    } chk_t;

    // reflected CRC-64 update, one byte
    function automatic logic [63:0] crc_feed(input logic [63:0] crc_in,
                                             input logic [7:0]  data);
        logic [63:0] c;
        c = crc_in ^ {56'd0, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### rtl/core/e2e_crc64_counter_check.sv
// E2E receive checker: top level with configuration registers and the three stages.
//
// Message bytes arrive on the s_ channel (s_valid/s_ready, s_data_byte, s_is_last),
// one byte per transfer in transmission order. Each byte updates a CRC-64/XZ register
// with the CRC-field bits cleared and captures CRC and counter field bits. The byte
// carrying s_is_last produces exactly one result on the m_ channel: check_status,
// sm_state, sm_error, lost_count and received_counter; other bytes produce none.
// Throughput: one byte per cycle while s_ready is high, back to back, messages included.
// The last byte loads the byte stage's message register, then the CRC fold/compare
// stage's check register and then the counter judge stage's result register, which
// drives m_valid.
// The result register parts the m_ side from the stages: when the receiver stalls,
// results back up one stage at a time and s_ready drops only once a finished message
// cannot leave the byte stage; bytes that do not end a message keep flowing until then.
// Configuration: cfg_we writes cfg_wdata into register cfg_index (0 CRC bit offset,
// 1 counter bit offset, 2 data id, 3 include data id, 4 max delta); writes take effect
// at once and are to be made only while no message is in flight. Unknown indexes are
// dropped.
// Reset (aresetn low at a clock edge) clears the message state, the counter history
// and all pipeline valids, and restores the register defaults.
module e2e_crc64_counter_check (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [e2ecc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [e2ecc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [7:0]                         s_data_byte,
    input  logic                               s_is_last,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [2:0]                         m_check_status,
    output logic [1:0]                         m_sm_state,
    output logic                               m_sm_error,
    output logic [7:0]                         m_lost_count,
    output logic [31:0]                        m_received_counter
);
    import e2ecc_pkg::*;

    cfg_t cfg_reg;
    logic msg_valid, msg_ready;
    msg_t msg;
    logic chk_valid, chk_ready;
    chk_t chk;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.crc_ofs   <= OFS_W'(0);
            cfg_reg.cnt_ofs   <= OFS_W'(64);
            cfg_reg.data_id   <= '0;
            cfg_reg.incl_id   <= 1'b0;
            cfg_reg.max_delta <= 8'd1;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_CRC_OFS:   cfg_reg.crc_ofs   <= cfg_wdata[OFS_W-1:0];
                CFG_CNT_OFS:   cfg_reg.cnt_ofs   <= cfg_wdata[OFS_W-1:0];
                CFG_DATA_ID:   cfg_reg.data_id   <= cfg_wdata[31:0];
                CFG_INCL_ID:   cfg_reg.incl_id   <= cfg_wdata[0];
                CFG_MAX_DELTA: cfg_reg.max_delta <= cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    e2ecc_accum u_accum (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_is_last   (s_is_last),
        .msg_valid   (msg_valid),
        .msg_ready   (msg_ready),
        .msg         (msg)
    );

    e2ecc_crc_cmp u_crc_cmp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .msg_valid (msg_valid),
        .msg_ready (msg_ready),
        .msg       (msg),
        .chk_valid (chk_valid),
        .chk_ready (chk_ready),
        .chk       (chk)
    );

    e2ecc_judge u_judge (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg                (cfg_reg),
        .chk_valid          (chk_valid),
        .chk_ready          (chk_ready),
        .chk                (chk),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_check_status     (m_check_status),
        .m_sm_state         (m_sm_state),
        .m_sm_error         (m_sm_error),
        .m_lost_count       (m_lost_count),
        .m_received_counter (m_received_counter)
    );

endmodule

### rtl/core/e2ecc_accum.sv
// Byte stage: field capture, CRC-field masking and CRC accumulation per message.
module e2ecc_accum (
    input  logic                aclk,
    input  logic                aresetn,
    input  e2ecc_pkg::cfg_t     cfg,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_data_byte,
    input  logic                s_is_last,
    output logic                msg_valid,
    input  logic                msg_ready,
    output e2ecc_pkg::msg_t     msg
);
    import e2ecc_pkg::*;

    logic [63:0]      crc_reg, crc_new;
    logic [63:0]      crc_cap_reg, crc_cap_next;
    logic [31:0]      cnt_cap_reg, cnt_cap_next;
    logic [IDX_W-1:0] idx_reg;
    logic             past_end_reg;
    logic             msg_valid_reg;
    msg_t             msg_reg;
    logic [7:0]       byte_m;
    logic [OFS_W-1:0] q, rel_crc, rel_cnt;
    logic [5:0]       pos;
    logic             aligned;
    logic             accept;

    assign s_ready   = !msg_valid_reg || msg_ready;
    assign accept    = s_valid && s_ready;
    assign msg_valid = msg_valid_reg;
    assign msg       = msg_reg;
    assign aligned   = (cfg.crc_ofs[2:0] == 3'd0);

    always_comb begin
        crc_cap_next = crc_cap_reg;
        cnt_cap_next = cnt_cap_reg;
        byte_m       = s_data_byte;
        q            = '0;
        rel_crc      = '0;
        rel_cnt      = '0;
        pos          = '0;
        if (!past_end_reg) begin
            for (int b = 0; b < 8; b++) begin
                q       = OFS_W'({idx_reg, 3'(b)});
                rel_crc = q - cfg.crc_ofs;
                rel_cnt = q - cfg.cnt_ofs;
                // aligned field is big-endian by byte, unaligned is bit-reversed
                pos     = aligned ? {~rel_crc[5:3], rel_crc[2:0]} : ~rel_crc[5:0];
                if ((q >= cfg.crc_ofs) && (rel_crc < OFS_W'(64))) begin
                    if (s_data_byte[b]) begin
                        crc_cap_next[pos] = 1'b1;
                    end
                    byte_m[b] = 1'b0;
                end
                if ((q >= cfg.cnt_ofs) && (rel_cnt < OFS_W'(32))) begin
                    if (s_data_byte[b]) begin
                        cnt_cap_next[rel_cnt[4:0]] = 1'b1;
                    end
                end
            end
        end
        crc_new = crc_feed(crc_reg, byte_m);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg       <= CRC_ALL_ONES;
            crc_cap_reg   <= '0;
            cnt_cap_reg   <= '0;
            idx_reg       <= '0;
            past_end_reg  <= 1'b0;
            msg_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                if (s_is_last) begin
                    crc_reg      <= CRC_ALL_ONES;
                    crc_cap_reg  <= '0;
                    cnt_cap_reg  <= '0;
                    idx_reg      <= '0;
                    past_end_reg <= 1'b0;
                end else begin
                    crc_reg     <= crc_new;
                    crc_cap_reg <= crc_cap_next;
                    cnt_cap_reg <= cnt_cap_next;
                    if (!past_end_reg) begin
                        if (idx_reg == IDX_W'(MAX_MESSAGE_BYTES - 1)) begin
                            past_end_reg <= 1'b1;
                        end else begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end
            end
            if (accept && s_is_last) begin
                msg_valid_reg <= 1'b1;
            end else if (msg_ready) begin
                msg_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_is_last) begin
            msg_reg.crc_calc <= crc_new;
            msg_reg.crc_rx   <= crc_cap_next;
            msg_reg.counter  <= cnt_cap_next;
        end
    end

endmodule

### rtl/core/e2ecc_crc_cmp.sv
// CRC stage: optional data-id fold, final xor and compare against the received CRC.
module e2ecc_crc_cmp (
    input  logic                aclk,
    input  logic                aresetn,
    input  e2ecc_pkg::cfg_t     cfg,
    input  logic                msg_valid,
    output logic                msg_ready,
    input  e2ecc_pkg::msg_t     msg,
    output logic                chk_valid,
    input  logic                chk_ready,
    output e2ecc_pkg::chk_t     chk
);
    import e2ecc_pkg::*;

    logic        chk_valid_reg;
    chk_t        chk_reg;
    logic [63:0] calc;
    logic        load;

    assign msg_ready = !chk_valid_reg || chk_ready;
    assign load      = msg_valid && msg_ready;
    assign chk_valid = chk_valid_reg;
    assign chk       = chk_reg;

    always_comb begin
        calc = msg.crc_calc;
        if (cfg.incl_id) begin
            // data id bytes go in little-endian order
            for (int b = 0; b < 4; b++) begin
                calc = crc_feed(calc, cfg.data_id[8*b +: 8]);
            end
        end
        calc = calc ^ CRC_ALL_ONES;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chk_valid_reg <= 1'b0;
        end else if (load) begin
            chk_valid_reg <= 1'b1;
        end else if (chk_ready) begin
            chk_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            chk_reg.crc_ok  <= (calc == msg.crc_rx);
            chk_reg.counter <= msg.counter;
        end
    end

endmodule

### rtl/core/e2ecc_judge.sv
// Counter stage: sequence judgement, counter history and the result register.
module e2ecc_judge (
    input  logic                aclk,
    input  logic                aresetn,
    input  e2ecc_pkg::cfg_t     cfg,
    input  logic                chk_valid,
    output logic                chk_ready,
    input  e2ecc_pkg::chk_t     chk,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [2:0]          m_check_status,
    output logic [1:0]          m_sm_state,
    output logic                m_sm_error,
    output logic [7:0]          m_lost_count,
    output logic [31:0]         m_received_counter
);
    import e2ecc_pkg::*;

    logic        m_valid_reg;
    status_t     status_reg, status_next;
    sm_state_t   sm_reg, sm_next;
    logic        err_reg, err_next;
    logic [7:0]  lost_out_reg;
    logic [31:0] cnt_out_reg;
    logic [31:0] last_good_reg, last_good_next;
    logic        seen_first_reg, seen_first_next;
    logic [7:0]  lost_record_reg, lost_record_next;
    logic [31:0] delta;
    logic        load;

    assign chk_ready = !m_valid_reg || m_ready;
    assign load      = chk_valid && chk_ready;
    assign delta     = chk.counter - last_good_reg;

    always_comb begin
        status_next      = ST_WRONG_CRC;
        last_good_next   = last_good_reg;
        seen_first_next  = seen_first_reg;
        lost_record_next = lost_record_reg;
        if (!chk.crc_ok) begin
            status_next = ST_WRONG_CRC;
        end else if (!seen_first_reg) begin
            status_next     = ST_INITIAL;
            last_good_next  = chk.counter;
            seen_first_next = 1'b1;
        end else if (delta == 32'd0) begin
            status_next = ST_REPEATED;
        end else if (delta == 32'd1) begin
            status_next    = ST_OK;
            last_good_next = chk.counter;
        end else if (delta <= {24'd0, cfg.max_delta}) begin
            status_next      = ST_OK_LOST;
            lost_record_next = delta[7:0] - 8'd1;
            last_good_next   = chk.counter;
        end else begin
            status_next    = ST_SYNC;
            last_good_next = chk.counter;
        end
    end

    always_comb begin
        case (status_next)
            ST_OK, ST_OK_LOST: begin
                sm_next  = SM_VALID;
                err_next = 1'b0;
            end
            ST_REPEATED, ST_WRONG_CRC: begin
                sm_next  = SM_INVALID;
                err_next = 1'b1;
            end
            ST_SYNC: begin
                sm_next  = SM_INIT;
                err_next = 1'b0;
            end
            default: begin
                sm_next  = SM_NODATA;
                err_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg     <= 1'b0;
            last_good_reg   <= '0;
            seen_first_reg  <= 1'b0;
            lost_record_reg <= '0;
        end else begin
            if (load) begin
                m_valid_reg     <= 1'b1;
                last_good_reg   <= last_good_next;
                seen_first_reg  <= seen_first_next;
                lost_record_reg <= lost_record_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            status_reg   <= status_next;
            sm_reg       <= sm_next;
            err_reg      <= err_next;
            lost_out_reg <= lost_record_next;
            cnt_out_reg  <= chk.counter;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_check_status     = status_reg;
    assign m_sm_state         = sm_reg;
    assign m_sm_error         = err_reg;
    assign m_lost_count       = lost_out_reg;
    assign m_received_counter = cnt_out_reg;

`ifndef SYNTH
    a_err_matches_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && err_reg |-> (status_reg == ST_REPEATED) ||
                                   (status_reg == ST_WRONG_CRC))
        else $error("error flag without repeated or wrong crc status");

    a_initial_sets_seen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (status_reg == ST_INITIAL) |-> seen_first_reg)
        else $error("initial status left first-message flag clear");

    a_lost_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (status_reg == ST_OK_LOST) |-> (lost_out_reg != 8'd0))
        else $error("some-lost status with zero lost count");

    a_history_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !load |=> $stable(last_good_reg) && $stable(lost_record_reg))
        else $error("counter history changed without a transfer");
`endif

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the E2E CRC-64 and sequence counter receive checker.
module tb_top;
    import e2ecc_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_BYTES = 1100;
    localparam int MAX_PRINTS = 20;

    typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_PERIODIC, RDY_MOSTLY} rdy_mode_t;

    typedef struct packed {
        status_t     st;
        sm_state_t   sm;
        logic        err;
        logic [7:0]  lost;
        logic [31:0] cnt;
    } verdict_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic [7:0]            s_data_byte;
    logic                  s_is_last;
    logic                  m_valid;
    logic                  m_ready;
    logic [2:0]            m_check_status;
    logic [1:0]            m_sm_state;
    logic                  m_sm_error;
    logic [7:0]            m_lost_count;
    logic [31:0]           m_received_counter;

    // register copy
    int        cfg_crc_ofs;
    int        cfg_cnt_ofs;
    bit [31:0] cfg_id;
    bit        cfg_incl;
    bit [7:0]  cfg_max;

    // message and counter history of the predictor
    bit [63:0] crc_run;
    int        msg_pos;
    bit [63:0] crc_seen;
    bit [31:0] cnt_seen;
    bit [31:0] cnt_prev;
    bit        have_first;
    bit [7:0]  lost_cnt;
    bit        overrun;

    verdict_t  pending_verdicts[$];
    bit [7:0]  frame [0:511];
    int        frame_len;

    int        bytes_sent;
    int        messages_sent;
    int        results_seen;
    int        mismatch_count;
    int        idle_cycles;
    int        status_hits [6];
    int        burst_left;
    bit        steady;
    int        hold_left;
    rdy_mode_t rdy_mode;
    int        rdy_timer;
    int        rdy_period;

    e2e_crc64_counter_check i_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_data_byte        (s_data_byte),
        .s_is_last          (s_is_last),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_check_status     (m_check_status),
        .m_sm_state         (m_sm_state),
        .m_sm_error         (m_sm_error),
        .m_lost_count       (m_lost_count),
        .m_received_counter (m_received_counter)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ---------------- predictor ----------------

    function automatic bit [63:0] crc64_byte(input bit [63:0] r, input bit [7:0] d);
        bit [63:0] c;
        bit        fb;
        c = r;
        for (int k = 0; k < 8; k++) begin
            fb = c[0] ^ d[k];
            c  = c >> 1;
            if (fb) c = c ^ CRC_POLY_REFL;
        end
        return c;
    endfunction

    // byte-aligned fields are big-endian by byte, otherwise bit-reversed
    function automatic int crc_bit_pos(input int rel);
        if (cfg_crc_ofs % 8 == 0) return 56 - 8 * (rel / 8) + rel % 8;
        return 63 - rel;
    endfunction

    function automatic void clear_message();
        crc_run  = CRC_ALL_ONES;
        msg_pos  = 0;
        crc_seen = '0;
        cnt_seen = '0;
        overrun  = 1'b0;
    endfunction

    function automatic void reset_model();
        cfg_crc_ofs = 0;
        cfg_cnt_ofs = 64;
        cfg_id      = '0;
        cfg_incl    = 1'b0;
        cfg_max     = 8'd1;
        clear_message();
        cnt_prev    = '0;
        have_first  = 1'b0;
        lost_cnt    = '0;
    endfunction

    function automatic void apply_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        case (idx)
            CFG_CRC_OFS:   cfg_crc_ofs = int'(val[OFS_W-1:0]);
            CFG_CNT_OFS:   cfg_cnt_ofs = int'(val[OFS_W-1:0]);
            CFG_DATA_ID:   cfg_id      = val;
            CFG_INCL_ID:   cfg_incl    = val[0];
            CFG_MAX_DELTA: cfg_max     = val[7:0];
            default: ;
        endcase
    endfunction

    // returns 1 when the byte closes a message, with the verdict in v
    function automatic bit absorb_byte(input bit [7:0] din, input bit last, output verdict_t v);
        bit [7:0]  hashed;
        bit [63:0] calc;
        bit [31:0] delta;
        int        q;
        status_t   st;
        hashed = din;
        v = '0;
        if (!overrun) begin
            for (int b = 0; b < 8; b++) begin
                q = msg_pos * 8 + b;
                if (q >= cfg_crc_ofs && q - cfg_crc_ofs < 64) begin
                    if (din[b]) crc_seen[crc_bit_pos(q - cfg_crc_ofs)] = 1'b1;
                    hashed[b] = 1'b0;
                end
                if (q >= cfg_cnt_ofs && q - cfg_cnt_ofs < 32 && din[b])
                    cnt_seen[q - cfg_cnt_ofs] = 1'b1;
            end
            if (msg_pos == MAX_MESSAGE_BYTES - 1) overrun = 1'b1;
            else msg_pos++;
        end
        crc_run = crc64_byte(crc_run, hashed);
        if (!last) return 1'b0;

        calc = crc_run;
        if (cfg_incl)
            for (int i = 0; i < 4; i++) calc = crc64_byte(calc, cfg_id[8 * i +: 8]);
        calc = ~calc;

        if (calc != crc_seen) begin
            st = ST_WRONG_CRC;
        end else if (!have_first) begin
            st = ST_INITIAL;
            cnt_prev = cnt_seen;
            have_first = 1'b1;
        end else begin
            delta = cnt_seen - cnt_prev;
            if (delta == 0) begin
                st = ST_REPEATED;
            end else if (delta == 1) begin
                st = ST_OK;
                cnt_prev = cnt_seen;
            end else if (delta <= cfg_max) begin
                st = ST_OK_LOST;
                lost_cnt = 8'(delta - 1);
                cnt_prev = cnt_seen;
            end else begin
                st = ST_SYNC;
                cnt_prev = cnt_seen;
            end
        end

        v.st = st;
        case (st)
            ST_OK, ST_OK_LOST: begin
                v.sm = SM_VALID;
                v.err = 1'b0;
            end
            ST_REPEATED, ST_WRONG_CRC: begin
                v.sm = SM_INVALID;
                v.err = 1'b1;
            end
            ST_SYNC: begin
                v.sm = SM_INIT;
                v.err = 1'b0;
            end
            default: begin
                v.sm = SM_NODATA;
                v.err = 1'b0;
            end
        endcase
        v.lost = lost_cnt;
        v.cnt  = cnt_seen;
        clear_message();
        return 1'b1;
    endfunction

    // well-formed message under the current registers: counter placed, CRC filled in
    function automatic void build_frame(input int len, input bit [31:0] cnt);
        bit [63:0] crc;
        int        q;
        frame_len = len;
        for (int i = 0; i < len; i++) frame[i] = 8'($urandom);
        for (int i = 0; i < 32; i++) begin
            q = cfg_cnt_ofs + i;
            if (q < 8 * len && q < 8 * MAX_MESSAGE_BYTES) frame[q / 8][q % 8] = cnt[i];
        end
        for (int i = 0; i < 64; i++) begin
            q = cfg_crc_ofs + i;
            if (q < 8 * len && q < 8 * MAX_MESSAGE_BYTES) frame[q / 8][q % 8] = 1'b0;
        end
        crc = CRC_ALL_ONES;
        for (int i = 0; i < len; i++) crc = crc64_byte(crc, frame[i]);
        if (cfg_incl)
            for (int i = 0; i < 4; i++) crc = crc64_byte(crc, cfg_id[8 * i +: 8]);
        crc = ~crc;
        for (int i = 0; i < 64; i++) begin
            q = cfg_crc_ofs + i;
            if (q < 8 * len && q < 8 * MAX_MESSAGE_BYTES) frame[q / 8][q % 8] = crc[crc_bit_pos(i)];
        end
    endfunction

    // counter step biased toward the interesting deltas
    function automatic bit [31:0] next_counter();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return cnt_prev;
        if (r <= 4) return cnt_prev + 1;
        if (r <= 6) return cnt_prev + $urandom_range(2, (cfg_max < 2) ? 2 : cfg_max);
        if (r == 7) return cnt_prev + cfg_max + $urandom_range(1, 300);
        if (r == 8) return cnt_prev + cfg_max;
        return $urandom;
    endfunction

    // ---------------- stimulus ----------------

    task automatic send_byte(input bit [7:0] b, input bit last);
        verdict_t v;
        int       gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = steady ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_valid     <= 1'b1;
        s_data_byte <= b;
        s_is_last   <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
        if (absorb_byte(b, last, v)) begin
            pending_verdicts.push_back(v);
            messages_sent++;
        end
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_len; i++) send_byte(frame[i], i == frame_len - 1);
    endtask

    task automatic send_checked(input int len, input bit [31:0] cnt);
        build_frame(len, cnt);
        send_frame();
    endtask

    task automatic sender_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic wait_drain();
        sender_idle();
        while (pending_verdicts.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        apply_cfg(idx, val);
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_random_message();
        int need;
        int len;
        int pick;
        int bitpos;
        need = (cfg_crc_ofs + 64 > cfg_cnt_ofs + 32) ? cfg_crc_ofs + 64 : cfg_cnt_ofs + 32;
        need = (need + 7) / 8;
        if (need > MAX_MESSAGE_BYTES) need = MAX_MESSAGE_BYTES;
        len = need + $urandom_range(0, 6);
        if (len > MAX_MESSAGE_BYTES) len = MAX_MESSAGE_BYTES;
        pick = $urandom_range(0, 99);
        if (pick < 3) len = $urandom_range(MAX_MESSAGE_BYTES + 1, MAX_MESSAGE_BYTES + 40);
        else if (pick < 8) len = $urandom_range(1, need);
        build_frame(len, next_counter());
        if (pick >= 80 && pick < 90) begin
            bitpos = $urandom_range(0, 8 * len - 1);
            frame[bitpos / 8][bitpos % 8] = ~frame[bitpos / 8][bitpos % 8];
        end else if (pick >= 90) begin
            frame_len = $urandom_range(1, 40);
            for (int i = 0; i < frame_len; i++) frame[i] = 8'($urandom);
        end
        send_frame();
    endtask

    // ---------------- tests ----------------

    task automatic test_directed_cases();
        // reset registers: CRC at bit 0, counter at bit 64, delta limit 1
        send_checked(12, 32'h0000_0005);    // first good message
        send_checked(12, 32'h0000_0005);    // repeated
        send_checked(12, 32'h0000_0006);    // ok
        send_checked(12, 32'h0000_0009);    // beyond limit
        build_frame(12, 32'h0000_000A);
        frame[3] = frame[3] ^ 8'h10;        // damaged CRC field
        send_frame();
        frame_len = 12;
        for (int i = 0; i < 12; i++) frame[i] = 8'h00;
        send_frame();
        for (int i = 0; i < 12; i++) frame[i] = 8'hFF;
        send_frame();
        send_byte(8'hA5, 1'b1);             // ends before either field is complete
        send_checked(12, 32'hFFFF_FFFF);
        send_checked(12, 32'h0000_0000);    // counter wraps
    endtask

    task automatic test_register_settings();
        wait_drain();
        cfg_write(CFG_CRC_OFS, 32'd3);      // unaligned CRC field
        cfg_write(CFG_CNT_OFS, 32'd100);
        cfg_write(CFG_DATA_ID, 32'hFFFF_FFFF);
        cfg_write(CFG_INCL_ID, 32'h1);
        cfg_write(CFG_MAX_DELTA, 32'd255);
        for (int i = CFG_MAX_DELTA + 1; i < (1 << CFG_IDX_W); i++)
            cfg_write(CFG_IDX_W'(i), 32'hFFFF_FFFF);
        send_checked(17, cnt_prev + 1);
        send_checked(17, cnt_prev + 200);
        send_checked(17, cnt_prev + 255);
        send_checked(17, cnt_prev + 256);
        wait_drain();
        // upper bits must be dropped by the register widths
        cfg_write(CFG_CRC_OFS, 32'hFFFF_F828);
        cfg_write(CFG_CNT_OFS, 32'hFFFF_F800);
        cfg_write(CFG_INCL_ID, 32'hFFFF_FFFE);
        cfg_write(CFG_DATA_ID, 32'h0);
        cfg_write(CFG_MAX_DELTA, 32'hFFFF_FF00);
        send_checked(17, cnt_prev + 2);
        send_checked(17, cnt_prev + 1);
        send_checked(MAX_MESSAGE_BYTES + 44, cnt_prev + 1);
    endtask

    task automatic test_backpressure();
        wait_drain();
        steady = 1'b1;
        burst_left = 0;
        hold_left = HOLD_CYCLES;
        repeat (40) send_byte(8'($urandom), 1'b1);
        repeat (3) send_random_message();
        steady = 1'b0;
        wait_drain();
    endtask

    task automatic set_phase_config(input int k);
        wait_drain();
        case (k)
            0: begin
                cfg_write(CFG_CRC_OFS, 32'd1984);
                cfg_write(CFG_CNT_OFS, 32'd0);
                cfg_write(CFG_DATA_ID, 32'h0);
                cfg_write(CFG_INCL_ID, 32'h0);
                cfg_write(CFG_MAX_DELTA, 32'd0);
            end
            1: begin
                cfg_write(CFG_CRC_OFS, 32'd0);
                cfg_write(CFG_CNT_OFS, 32'd2016);
                cfg_write(CFG_DATA_ID, 32'hFFFF_FFFF);
                cfg_write(CFG_INCL_ID, 32'h1);
                cfg_write(CFG_MAX_DELTA, 32'd255);
            end
            2: begin
                cfg_write(CFG_CRC_OFS, 32'hFFFF_FFFF);
                cfg_write(CFG_CNT_OFS, 32'h0000_FFFF);
                cfg_write(CFG_DATA_ID, $urandom);
                cfg_write(CFG_INCL_ID, 32'h1);
                cfg_write(CFG_MAX_DELTA, 32'd1);
            end
            default: begin
                cfg_write(CFG_CRC_OFS, ($urandom_range(0, 3) == 0) ?
                          $urandom_range(0, 2047) : $urandom_range(0, 160));
                cfg_write(CFG_CNT_OFS, ($urandom_range(0, 3) == 0) ?
                          $urandom_range(0, 2047) : $urandom_range(0, 160));
                cfg_write(CFG_DATA_ID, $urandom);
                cfg_write(CFG_INCL_ID, $urandom_range(0, 1));
                case ($urandom_range(0, 3))
                    0: cfg_write(CFG_MAX_DELTA, 32'd0);
                    1: cfg_write(CFG_MAX_DELTA, 32'd1);
                    2: cfg_write(CFG_MAX_DELTA, 32'd255);
                    default: cfg_write(CFG_MAX_DELTA, $urandom_range(2, 254));
                endcase
            end
        endcase
    endtask

    task automatic test_random_configs();
        int k;
        int base_bytes;
        int phase_bytes;
        k = 0;
        base_bytes = bytes_sent;
        while (bytes_sent - base_bytes < RANDOM_BYTES) begin
            set_phase_config(k);
            steady = ($urandom_range(0, 3) == 0);
            phase_bytes = bytes_sent;
            while (bytes_sent - phase_bytes < 220) send_random_message();
            k++;
        end
        steady = 1'b0;
    endtask

    // ---------------- result side ----------------

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_count < MAX_PRINTS)
            $display("%0t: mismatch on result %0d, %s: got %0h, want %0h",
                     $time, results_seen, what, got, want);
        mismatch_count++;
    endtask

    always @(negedge aclk) begin
        if (rdy_timer <= 0) begin
            rdy_mode   = rdy_mode_t'($urandom_range(0, 3));
            rdy_timer  = $urandom_range(20, 120);
            rdy_period = $urandom_range(2, 6);
        end
        rdy_timer--;
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else begin
            case (rdy_mode)
                RDY_ALWAYS:   m_ready <= 1'b1;
                RDY_COIN:     m_ready <= 1'($urandom_range(0, 1));
                RDY_PERIODIC: m_ready <= (rdy_timer % rdy_period) != 0;
                default:      m_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        verdict_t want;
        if (!aresetn) begin
            idle_cycles = 0;
        end else begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (m_valid && m_ready) begin
                results_seen++;
                if (m_check_status <= ST_WRONG_CRC) status_hits[m_check_status]++;
                if (pending_verdicts.size() == 0) begin
                    report_mismatch("transfer with nothing pending", m_check_status, '0);
                end else begin
                    want = pending_verdicts.pop_front();
                    if (m_check_status !== want.st)
                        report_mismatch("check_status", m_check_status, want.st);
                    if (m_sm_state !== want.sm)
                        report_mismatch("sm_state", m_sm_state, want.sm);
                    if (m_sm_error !== want.err)
                        report_mismatch("sm_error", m_sm_error, want.err);
                    if (m_lost_count !== want.lost)
                        report_mismatch("lost_count", m_lost_count, want.lost);
                    if (m_received_counter !== want.cnt)
                        report_mismatch("received_counter", m_received_counter, want.cnt);
                end
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                         $time, idle_cycles, pending_verdicts.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        aresetn     = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_wdata   = '0;
        s_valid     = 1'b0;
        s_data_byte = '0;
        s_is_last   = 1'b0;
        m_ready     = 1'b0;
        burst_left  = 0;
        steady      = 1'b0;
        hold_left   = 0;
        rdy_timer   = 0;
        reset_model();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_cases();
        test_register_settings();
        test_backpressure();
        test_random_configs();
        wait_drain();

        $display("Run covered %0d bytes in %0d messages, %0d results checked, %0d mismatches.",
                 bytes_sent, messages_sent, results_seen, mismatch_count);
        $display("Verdicts initial/ok/lost/repeated/sync/bad crc: %0d/%0d/%0d/%0d/%0d/%0d",
                 status_hits[0], status_hits[1], status_hits[2],
                 status_hits[3], status_hits[4], status_hits[5]);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
